### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rpn_pkg.sv
// shared constants, types and helper functions of the rpn stack calculator
package rpn_pkg;

    // sizes
    localparam int STACK_DEPTH = 128;
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int AW          = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int DIV_W       = DATA_W + FRAC_BITS;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int CNT_W       = $clog2(DIV_W);
    localparam int MODE_W      = 4;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_W     = 8;

    // stream port widths
    localparam int S_TDATA_W   = DATA_W;
    localparam int S_TUSER_W   = MODE_W;
    localparam int M_TDATA_W   = 48;
    localparam int M_TUSER_W   = 1;
    localparam int M_PAD_W     = M_TDATA_W - DATA_W - STATUS_W - DEPTH_W;

    // command modes
    localparam logic [MODE_W-1:0] MODE_PUSH  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SUB   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_MUL   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DIV   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_MOD   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_POP   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_PEEK  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_DUP   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_SWAP  = 4'd9;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 4'd10;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZDIV  = 2'd3;

    // iterative unit operations
    localparam logic ALU_MUL = 1'b0;
    localparam logic ALU_DIV = 1'b1;

    // saturation limits
    localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // command to the iterative unit
    typedef struct packed {
        logic              start;
        logic              op;
        logic [DIV_W-1:0]  x;
        logic [DATA_W-1:0] y;
    } alu_cmd_t;

    // state of the iterative unit
    typedef struct packed {
        logic              busy;
        logic [DATA_W-1:0] hi;
        logic [DIV_W-1:0]  lo;
    } alu_res_t;

    // stack memory access
    typedef struct packed {
        logic              wr_en;
        logic [AW-1:0]     wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [AW-1:0]     rd_addr;
    } mem_req_t;

    // magnitude of a two's complement value, most negative value maps to 2^(w-1)
    function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(~v + DATA_W'(1)) : v;
    endfunction

    // signed value from sign and magnitude, saturated to the data range
    function automatic logic [DATA_W-1:0] sat_mag(input logic neg,
                                                  input logic [PROD_W-1:0] mag);
        logic big;
        big = |mag[PROD_W-1:DATA_W-1];
        if (neg) begin
            return big ? Q_MIN : DATA_W'(~mag[DATA_W-1:0] + DATA_W'(1));
        end
        return big ? Q_MAX : mag[DATA_W-1:0];
    endfunction

endpackage

### src/rpn_stack_mem.sv
// stack entry memory, one write port and one registered read port
module rpn_stack_mem (
    input  logic                           aclk,
    input  rpn_pkg::mem_req_t              req,
    output logic [rpn_pkg::DATA_W-1:0]     rd_data
);

    logic [rpn_pkg::DATA_W-1:0] stack_mem [rpn_pkg::STACK_DEPTH];
    logic [rpn_pkg::DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            stack_mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= stack_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/rpn_alu.sv
// shared iterative unit: shift-add multiply and restoring divide over one adder
module rpn_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  rpn_pkg::alu_cmd_t cmd,
    output rpn_pkg::alu_res_t res
);

    logic                         busy_reg, busy_next;
    logic                         op_reg, op_next;
    logic [rpn_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [rpn_pkg::DATA_W-1:0]   y_reg, y_next;
    logic [rpn_pkg::DATA_W-1:0]   hi_reg, hi_next;
    logic [rpn_pkg::DIV_W-1:0]    lo_reg, lo_next;

    logic [rpn_pkg::DATA_W:0]     add_a;
    logic [rpn_pkg::DATA_W:0]     add_b;
    logic                         sub;
    logic [rpn_pkg::DATA_W+1:0]   sum;
    logic                         ge;

    // operand selection for the one adder
    always_comb begin
        if (op_reg == rpn_pkg::ALU_DIV) begin
            add_a = {hi_reg, lo_reg[rpn_pkg::DIV_W-1]};
            add_b = {1'b0, y_reg};
            sub   = 1'b1;
        end else begin
            add_a = {1'b0, hi_reg};
            add_b = lo_reg[0] ? {1'b0, y_reg} : '0;
            sub   = 1'b0;
        end
    end

    // shared adder, carry out doubles as the divide compare
    assign sum = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)}
               + (rpn_pkg::DATA_W+2)'(sub);
    assign ge  = sum[rpn_pkg::DATA_W+1];

    // one step per cycle while busy
    always_comb begin
        busy_next = busy_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        y_next    = y_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            y_next    = cmd.y;
            hi_next   = '0;
            lo_next   = cmd.x;
            cnt_next  = (cmd.op == rpn_pkg::ALU_MUL) ? rpn_pkg::CNT_W'(rpn_pkg::DATA_W - 1)
                                                     : rpn_pkg::CNT_W'(rpn_pkg::DIV_W - 1);
        end else if (busy_reg) begin
            if (op_reg == rpn_pkg::ALU_DIV) begin
                hi_next = ge ? sum[rpn_pkg::DATA_W-1:0] : add_a[rpn_pkg::DATA_W-1:0];
                lo_next = {lo_reg[rpn_pkg::DIV_W-2:0], ge};
            end else begin
                hi_next = sum[rpn_pkg::DATA_W:1];
                lo_next = {lo_reg[rpn_pkg::DIV_W-1:rpn_pkg::DATA_W], sum[0],
                           lo_reg[rpn_pkg::DATA_W-1:1]};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - rpn_pkg::CNT_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            op_reg   <= rpn_pkg::ALU_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        y_reg  <= y_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign res.busy = busy_reg;
    assign res.hi   = hi_reg;
    assign res.lo   = lo_reg;

endmodule

### src/rpn_stack_calculator.sv
// Reverse Polish calculator on signed Q16.16 values with a 128-entry stack.
// Each input beat carries a mode in s_tuser and an operand in s_tdata, and
// gives exactly one result beat: the popped or peeked value, its valid flag,
// a status code (ok, underflow, overflow, zero divisor) and the stack depth
// after the step. One command is worked on at a time and s_tready is low
// until its result has been loaded into the output register, which can still
// wait for m_tready while the next command is taken. After decode, push, clear
// and unused modes go straight to the result load; pop and peek pass through
// a show step, dup through a write (not on an empty or full stack), add and
// sub through loading both operands, and swap through one read and two
// writes. Multiply takes 32 steps of the shared shift-add unit; divide and
// modulo take 48 restoring steps of the same unit (one per quotient bit of
// the 48-bit dividend, scaled for divide), skipped when the divisor is zero.
// s_tready comes back as the result is loaded, and the load itself waits while
// an earlier result beat is still stalled. Sums, products and quotients saturate.
module rpn_stack_calculator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rpn_pkg::S_TDATA_W-1:0]     s_tdata,  // operand[31:0]
    input  logic [rpn_pkg::S_TUSER_W-1:0]     s_tuser,  // mode[3:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rpn_pkg::M_TDATA_W-1:0]     m_tdata,  // shown_value[31:0], status[33:32],
                                                        // depth[41:34], zero pad[47:42]
    output logic [rpn_pkg::M_TUSER_W-1:0]     m_tuser   // shown_valid[0]
);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_LOAD_B   = 4'd2;
    localparam logic [3:0] S_LOAD_A   = 4'd3;
    localparam logic [3:0] S_RUN      = 4'd4;
    localparam logic [3:0] S_SHOW     = 4'd5;
    localparam logic [3:0] S_DUP_WR   = 4'd6;
    localparam logic [3:0] S_SWAP_RD  = 4'd7;
    localparam logic [3:0] S_SWAP_WR1 = 4'd8;
    localparam logic [3:0] S_SWAP_WR2 = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0]                       state_reg, state_next;
    logic [rpn_pkg::SP_W-1:0]         sp_reg, sp_next;
    logic                             hit_reg, hit_next;
    logic                             under_reg, under_next;
    logic [rpn_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic                             m_tvalid_reg, m_tvalid_next;

    logic [rpn_pkg::MODE_W-1:0]       mode_reg, mode_next;
    logic [rpn_pkg::DATA_W-1:0]       operand_reg, operand_next;
    logic [rpn_pkg::DATA_W-1:0]       b_reg, b_next;
    logic [rpn_pkg::DATA_W-1:0]       bmag_reg, bmag_next;
    logic [rpn_pkg::DATA_W-1:0]       a_reg, a_next;
    logic                             neg_reg, neg_next;
    logic [rpn_pkg::DATA_W-1:0]       shown_reg, shown_next;
    logic                             shown_valid_reg, shown_valid_next;

    logic [rpn_pkg::DATA_W-1:0]       out_value_reg, out_value_next;
    logic                             out_flag_reg, out_flag_next;
    logic [rpn_pkg::STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [rpn_pkg::DEPTH_W-1:0]      out_depth_reg, out_depth_next;

    rpn_pkg::mem_req_t                mem_req;
    logic [rpn_pkg::DATA_W-1:0]       mem_rd_data;
    rpn_pkg::alu_cmd_t                alu_cmd;
    rpn_pkg::alu_res_t                alu_res;

    // stack storage
    rpn_stack_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // shared multiply / divide unit
    rpn_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (alu_cmd),
        .res     (alu_res)
    );

    assign s_tready = (state_reg == S_IDLE);

    // sequencer
    always_comb begin
        logic [rpn_pkg::DATA_W-1:0] rd_val;
        logic [rpn_pkg::DATA_W-1:0] amag;
        logic [rpn_pkg::DATA_W:0]   sum_ext;
        logic [rpn_pkg::SP_W-1:0]   sp_dec;
        logic [rpn_pkg::SP_W-1:0]   sp_dec2;
        logic [rpn_pkg::PROD_W-1:0] alu_mag;
        logic                       b_zero;

        state_next       = state_reg;
        sp_next          = sp_reg;
        hit_next         = hit_reg;
        under_next       = under_reg;
        status_next      = status_reg;
        mode_next        = mode_reg;
        operand_next     = operand_reg;
        b_next           = b_reg;
        bmag_next        = bmag_reg;
        a_next           = a_reg;
        neg_next         = neg_reg;
        shown_next       = shown_reg;
        shown_valid_next = shown_valid_reg;
        out_value_next   = out_value_reg;
        out_flag_next    = out_flag_reg;
        out_status_next  = out_status_reg;
        out_depth_next   = out_depth_reg;
        m_tvalid_next    = m_tready ? 1'b0 : m_tvalid_reg;

        mem_req          = '0;
        alu_cmd          = '0;

        rd_val  = hit_reg ? mem_rd_data : '0;
        amag    = rpn_pkg::mag_of(rd_val);
        sp_dec  = sp_reg - rpn_pkg::SP_W'(1);
        sp_dec2 = sp_reg - rpn_pkg::SP_W'(2);
        sum_ext = '0;
        alu_mag = '0;
        b_zero  = 1'b0;

        unique case (state_reg)
            // take a command beat
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next        = s_tuser;
                    operand_next     = s_tdata;
                    hit_next         = 1'b0;
                    under_next       = 1'b0;
                    status_next      = rpn_pkg::ST_OK;
                    shown_next       = '0;
                    shown_valid_next = 1'b0;
                    state_next       = S_DECODE;
                end
            end

            // first step of each mode, with its first stack access if it has one
            S_DECODE: begin
                state_next = S_DONE;
                unique case (mode_reg) inside
                    rpn_pkg::MODE_PUSH: begin
                        if (sp_reg < rpn_pkg::SP_W'(rpn_pkg::STACK_DEPTH)) begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = sp_reg[rpn_pkg::AW-1:0];
                            mem_req.wr_data = operand_reg;
                            sp_next         = sp_reg + rpn_pkg::SP_W'(1);
                        end else begin
                            status_next = rpn_pkg::ST_OVER;
                        end
                    end
                    rpn_pkg::MODE_ADD, rpn_pkg::MODE_SUB, rpn_pkg::MODE_MUL,
                    rpn_pkg::MODE_DIV, rpn_pkg::MODE_MOD, rpn_pkg::MODE_POP: begin
                        if (sp_reg != '0) begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = sp_dec[rpn_pkg::AW-1:0];
                            sp_next         = sp_dec;
                            hit_next        = 1'b1;
                        end else begin
                            hit_next   = 1'b0;
                            under_next = 1'b1;
                        end
                        state_next = (mode_reg == rpn_pkg::MODE_POP) ? S_SHOW : S_LOAD_B;
                    end
                    rpn_pkg::MODE_PEEK: begin
                        if (sp_reg != '0) begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = sp_dec[rpn_pkg::AW-1:0];
                            hit_next        = 1'b1;
                        end else begin
                            under_next = 1'b1;
                        end
                        state_next = S_SHOW;
                    end
                    rpn_pkg::MODE_DUP: begin
                        if (sp_reg == '0) begin
                            under_next = 1'b1;
                        end else if (sp_reg >= rpn_pkg::SP_W'(rpn_pkg::STACK_DEPTH)) begin
                            status_next = rpn_pkg::ST_OVER;
                        end else begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = sp_dec[rpn_pkg::AW-1:0];
                            state_next      = S_DUP_WR;
                        end
                    end
                    rpn_pkg::MODE_SWAP: begin
                        if (sp_reg >= rpn_pkg::SP_W'(2)) begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = sp_dec[rpn_pkg::AW-1:0];
                            state_next      = S_SWAP_RD;
                        end else begin
                            under_next = 1'b1;
                        end
                    end
                    rpn_pkg::MODE_CLEAR: begin
                        if (sp_reg != '0) begin
                            sp_next = '0;
                        end else begin
                            under_next = 1'b1;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // right operand in, zero divisor check, pop left operand
            S_LOAD_B: begin
                b_next    = rd_val;
                bmag_next = amag;
                if (mode_reg == rpn_pkg::MODE_DIV) begin
                    b_zero = (amag == '0);
                end else if (mode_reg == rpn_pkg::MODE_MOD) begin
                    b_zero = ((amag >> rpn_pkg::FRAC_BITS) == '0);
                end
                if (b_zero) begin
                    if (!under_reg) begin
                        status_next = rpn_pkg::ST_ZDIV;
                    end
                    state_next = S_DONE;
                end else begin
                    if (sp_reg != '0) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = sp_dec[rpn_pkg::AW-1:0];
                        sp_next         = sp_dec;
                        hit_next        = 1'b1;
                    end else begin
                        hit_next   = 1'b0;
                        under_next = 1'b1;
                    end
                    state_next = S_LOAD_A;
                end
            end

            // left operand in: add and sub finish here, the rest start the unit
            S_LOAD_A: begin
                neg_next = rd_val[rpn_pkg::DATA_W-1] ^ b_reg[rpn_pkg::DATA_W-1];
                if (mode_reg == rpn_pkg::MODE_ADD || mode_reg == rpn_pkg::MODE_SUB) begin
                    if (mode_reg == rpn_pkg::MODE_ADD) begin
                        sum_ext = {rd_val[rpn_pkg::DATA_W-1], rd_val}
                                + {b_reg[rpn_pkg::DATA_W-1], b_reg};
                    end else begin
                        sum_ext = {rd_val[rpn_pkg::DATA_W-1], rd_val}
                                - {b_reg[rpn_pkg::DATA_W-1], b_reg};
                    end
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = sp_reg[rpn_pkg::AW-1:0];
                    if (sum_ext[rpn_pkg::DATA_W] != sum_ext[rpn_pkg::DATA_W-1]) begin
                        mem_req.wr_data = sum_ext[rpn_pkg::DATA_W] ? rpn_pkg::Q_MIN
                                                                   : rpn_pkg::Q_MAX;
                    end else begin
                        mem_req.wr_data = sum_ext[rpn_pkg::DATA_W-1:0];
                    end
                    sp_next    = sp_reg + rpn_pkg::SP_W'(1);
                    state_next = S_DONE;
                end else begin
                    alu_cmd.start = 1'b1;
                    if (mode_reg == rpn_pkg::MODE_MUL) begin
                        alu_cmd.op = rpn_pkg::ALU_MUL;
                        alu_cmd.x  = rpn_pkg::DIV_W'(bmag_reg);
                        alu_cmd.y  = amag;
                    end else if (mode_reg == rpn_pkg::MODE_DIV) begin
                        alu_cmd.op = rpn_pkg::ALU_DIV;
                        alu_cmd.x  = rpn_pkg::DIV_W'(amag) << rpn_pkg::FRAC_BITS;
                        alu_cmd.y  = bmag_reg;
                    end else begin
                        // modulo keeps the sign of the left operand
                        neg_next   = rd_val[rpn_pkg::DATA_W-1];
                        alu_cmd.op = rpn_pkg::ALU_DIV;
                        alu_cmd.x  = rpn_pkg::DIV_W'(amag >> rpn_pkg::FRAC_BITS);
                        alu_cmd.y  = bmag_reg >> rpn_pkg::FRAC_BITS;
                    end
                    state_next = S_RUN;
                end
            end

            // wait for the unit, saturate and push the result
            S_RUN: begin
                if (!alu_res.busy) begin
                    if (mode_reg == rpn_pkg::MODE_MUL) begin
                        alu_mag = {alu_res.hi, alu_res.lo[rpn_pkg::DATA_W-1:0]}
                                  >> rpn_pkg::FRAC_BITS;
                    end else if (mode_reg == rpn_pkg::MODE_DIV) begin
                        alu_mag = rpn_pkg::PROD_W'(alu_res.lo);
                    end else begin
                        alu_mag = rpn_pkg::PROD_W'(alu_res.hi) << rpn_pkg::FRAC_BITS;
                    end
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = sp_reg[rpn_pkg::AW-1:0];
                    mem_req.wr_data = rpn_pkg::sat_mag(neg_reg, alu_mag);
                    sp_next         = sp_reg + rpn_pkg::SP_W'(1);
                    state_next      = S_DONE;
                end
            end

            // pop or peek value
            S_SHOW: begin
                shown_next       = rd_val;
                shown_valid_next = hit_reg;
                state_next       = S_DONE;
            end

            // copy of the top entry
            S_DUP_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = sp_reg[rpn_pkg::AW-1:0];
                mem_req.wr_data = mem_rd_data;
                sp_next         = sp_reg + rpn_pkg::SP_W'(1);
                state_next      = S_DONE;
            end

            // swap: hold the top, read the one below
            S_SWAP_RD: begin
                b_next          = mem_rd_data;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = sp_dec2[rpn_pkg::AW-1:0];
                state_next      = S_SWAP_WR1;
            end

            S_SWAP_WR1: begin
                a_next          = mem_rd_data;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = sp_dec2[rpn_pkg::AW-1:0];
                mem_req.wr_data = b_reg;
                state_next      = S_SWAP_WR2;
            end

            S_SWAP_WR2: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = sp_dec[rpn_pkg::AW-1:0];
                mem_req.wr_data = a_reg;
                state_next      = S_DONE;
            end

            // load the result beat once the output register is free
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_value_next  = shown_reg;
                    out_flag_next   = shown_valid_reg;
                    out_status_next = under_reg ? rpn_pkg::ST_UNDER : status_reg;
                    out_depth_next  = rpn_pkg::DEPTH_W'(sp_reg);
                    m_tvalid_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            sp_reg       <= '0;
            hit_reg      <= 1'b0;
            under_reg    <= 1'b0;
            status_reg   <= rpn_pkg::ST_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sp_reg       <= sp_next;
            hit_reg      <= hit_next;
            under_reg    <= under_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mode_reg        <= mode_next;
        operand_reg     <= operand_next;
        b_reg           <= b_next;
        bmag_reg        <= bmag_next;
        a_reg           <= a_next;
        neg_reg         <= neg_next;
        shown_reg       <= shown_next;
        shown_valid_reg <= shown_valid_next;
        out_value_reg   <= out_value_next;
        out_flag_reg    <= out_flag_next;
        out_status_reg  <= out_status_next;
        out_depth_reg   <= out_depth_next;
    end

    // result beat
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{rpn_pkg::M_PAD_W{1'b0}}, out_depth_reg, out_status_reg, out_value_reg};
    assign m_tuser  = out_flag_reg;

endmodule

### src/rpn_checker.sv
// port-level checks of the rpn stack calculator and their bind
`include "assert_macros.svh"

module rpn_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [rpn_pkg::S_TDATA_W-1:0]     s_tdata,
    input logic [rpn_pkg::S_TUSER_W-1:0]     s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rpn_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic [rpn_pkg::M_TUSER_W-1:0]     m_tuser
);

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // one command at a time: ready drops after each accepted beat
    `ASSERT_NEXT(a_one_cmd, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second command taken while busy")

    // reported depth never exceeds the stack size
    `ASSERT_IMPL(a_depth_range, aclk, aresetn, m_tvalid, m_tdata[41:34] <= 8'(rpn_pkg::STACK_DEPTH), "depth beyond stack size")

    // a shown value always comes with ok status
    `ASSERT_IMPL(a_shown_ok, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[33:32] == rpn_pkg::ST_OK, "shown value with error status")

    // no shown value means a zero value field
    `ASSERT_IMPL(a_unshown_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[31:0] == '0, "value field set without shown flag")

    // unused here but part of the port view
    logic unused_in;
    assign unused_in = ^{s_tdata, s_tuser};

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
